// ===== rtl/core/irbn_pkg.sv =====
// ----------------------------------------------------------------------------
// irbn_pkg
// shared widths, register indexes, reset values and word types of the scaler
// ----------------------------------------------------------------------------
package irbn_pkg;

	// field widths
	localparam int COL_W      = 12;
	localparam int ROW_W      = 12;
	localparam int PIX_W      = 32;
	localparam int PIX_BYTES  = 4;
	localparam int SRC_DIM_W  = 9;
	localparam int DST_DIM_W  = 13;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int NUM_W      = COL_W + SRC_DIM_W;
	localparam int ACC_W      = 10;

	// parameter defaults
	localparam int MAX_SRC_WIDTH_DEF  = 256;
	localparam int MAX_SRC_HEIGHT_DEF = 256;
	localparam int MAX_BYTES_DEF      = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd5;

	// register reset values
	localparam logic [SRC_DIM_W-1:0] SRC_WIDTH_RST  = 9'd256;
	localparam logic [SRC_DIM_W-1:0] SRC_HEIGHT_RST = 9'd256;
	localparam logic [DST_DIM_W-1:0] DST_WIDTH_RST  = 13'd256;
	localparam logic [DST_DIM_W-1:0] DST_HEIGHT_RST = 13'd256;
	localparam logic [BPP_W-1:0]     BPP_RST        = 3'd4;

	// sample modes
	localparam logic MODE_BOX     = 1'b0;
	localparam logic MODE_NEAREST = 1'b1;

	// item commands
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_REQUEST = 1'b1;

	// result status
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// neighbor select: bit 0 steps right, bit 1 steps down
	localparam logic [1:0] NBR_BASE  = 2'd0;
	localparam logic [1:0] NBR_LAST  = 2'd3;

	typedef struct packed {
		logic             cmd;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             status;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       wr;
		logic       div_init;
		logic       div_step;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       emit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_req;
		logic oob;
		logic nearest;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== rtl/core/irbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// irbn_ctrl
// sequencer: accept, decode, divide, neighbor reads, emit
// ----------------------------------------------------------------------------
module irbn_ctrl
	import irbn_pkg::*;
#(
	parameter int DIV_STEPS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_DRAIN = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] div_cnt_q;
	logic [1:0]       rd_cnt_q;
	logic             rd_last;

	// nearest needs only the base pixel
	assign rd_last = sts.nearest ? (rd_cnt_q == NBR_BASE) : (rd_cnt_q == NBR_LAST);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!sts.is_req) begin
					cmd.wr  = 1'b1;
					state_d = S_IDLE;
				end else if (sts.oob) begin
					state_d = S_EMIT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = rd_cnt_q;
				if (rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			rd_cnt_q  <= NBR_BASE;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				div_cnt_q <= '0;
				rd_cnt_q  <= NBR_BASE;
			end else begin
				if (cmd.div_step) begin
					div_cnt_q <= div_cnt_q + CNT_W'(1);
				end
				if (cmd.rd_en) begin
					rd_cnt_q <= rd_cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/irbn_datapath.sv =====
// ----------------------------------------------------------------------------
// irbn_datapath
// config registers, coordinate dividers, frame store, byte accumulators, output
// ----------------------------------------------------------------------------
module irbn_datapath
	import irbn_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
	parameter int MAX_BYTES      = MAX_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_word_t              in_word,
	input  ctl_cmd_t              cmd,
	output ctl_sts_t              sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word
);

	localparam int XW    = $clog2(MAX_SRC_WIDTH);
	localparam int YW    = $clog2(MAX_SRC_HEIGHT);
	localparam int QW    = (XW > YW) ? XW : YW;
	localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = DST_DIM_W;
	localparam int NB_HI = (MAX_BYTES < PIX_BYTES) ? MAX_BYTES : PIX_BYTES;

	localparam logic [DST_DIM_W-1:0] MAX_W_C = DST_DIM_W'(MAX_SRC_WIDTH);
	localparam logic [DST_DIM_W-1:0] MAX_H_C = DST_DIM_W'(MAX_SRC_HEIGHT);

	// configuration
	logic [SRC_DIM_W-1:0] src_w_q, src_h_q, sw, sh;
	logic [DST_DIM_W-1:0] dst_w_q, dst_h_q, dw, dh;
	logic [BPP_W-1:0]     bpp_q, nb;
	logic                 mode_q;

	// latched item
	logic             is_req_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] pix_q;
	logic [NUM_W-1:0] num_x_q, num_y_q;

	// dividers
	logic [RW-1:0]    rx_q, ry_q;
	logic [QW-1:0]    nx_q, ny_q, qx_q, qy_q;
	logic [NUM_W-1:0] nx_init, ny_init;
	logic [RW:0]      rx_sh, ry_sh, rx_sub, ry_sub;
	logic             gex, gey;
	logic [QW:0]      qx_sh, qy_sh, nx_sh, ny_sh;

	// neighbor coordinates
	logic [XW-1:0] ox, ox1, ax;
	logic [YW-1:0] oy, oy1, ay;
	logic [XW:0]   ox_inc;
	logic [YW:0]   oy_inc;

	// frame store
	logic [PIX_W-1:0] mem [DEPTH];
	logic [AW-1:0]    addr;
	logic             wr_ok, mem_we;
	logic [PIX_W-1:0] rd_data_s1;
	logic             rd_vld_s1, rd_first_s1;

	logic [ACC_W-1:0] acc_q [PIX_BYTES];
	logic [PIX_W-1:0] result;
	logic             out_valid_q;
	out_word_t        out_word_q;

	// effective register values
	always_comb begin
		if (src_w_q == '0) begin
			sw = SRC_DIM_W'(1);
		end else if (DST_DIM_W'(src_w_q) > MAX_W_C) begin
			sw = SRC_DIM_W'(MAX_SRC_WIDTH);
		end else begin
			sw = src_w_q;
		end
		if (src_h_q == '0) begin
			sh = SRC_DIM_W'(1);
		end else if (DST_DIM_W'(src_h_q) > MAX_H_C) begin
			sh = SRC_DIM_W'(MAX_SRC_HEIGHT);
		end else begin
			sh = src_h_q;
		end
		dw = (dst_w_q == '0) ? DST_DIM_W'(1) : dst_w_q;
		dh = (dst_h_q == '0) ? DST_DIM_W'(1) : dst_h_q;
		if (bpp_q == '0) begin
			nb = BPP_W'(1);
		end else if (bpp_q > BPP_W'(NB_HI)) begin
			nb = BPP_W'(NB_HI);
		end else begin
			nb = bpp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_WIDTH_RST;
			src_h_q <= SRC_HEIGHT_RST;
			dst_w_q <= DST_WIDTH_RST;
			dst_h_q <= DST_HEIGHT_RST;
			bpp_q   <= BPP_RST;
			mode_q  <= MODE_BOX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_WIDTH:  src_w_q <= cfg_data[SRC_DIM_W-1:0];
				CFG_SRC_HEIGHT: src_h_q <= cfg_data[SRC_DIM_W-1:0];
				CFG_DST_WIDTH:  dst_w_q <= cfg_data[DST_DIM_W-1:0];
				CFG_DST_HEIGHT: dst_h_q <= cfg_data[DST_DIM_W-1:0];
				CFG_BPP:        bpp_q   <= cfg_data[BPP_W-1:0];
				CFG_MODE:       mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item capture and scaled numerators
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			is_req_q <= (in_word.cmd == CMD_REQUEST);
			col_q    <= in_word.col;
			row_q    <= in_word.row;
			pix_q    <= in_word.pixel_in;
			num_x_q  <= NUM_W'(in_word.col) * NUM_W'(sw);
			num_y_q  <= NUM_W'(in_word.row) * NUM_W'(sh);
		end
	end

	// restoring dividers, one quotient bit per step; quotient fits in QW bits
	assign nx_init = num_x_q >> QW;
	assign ny_init = num_y_q >> QW;
	assign rx_sh   = {rx_q, nx_q[QW-1]};
	assign ry_sh   = {ry_q, ny_q[QW-1]};
	assign gex     = (rx_sh >= {1'b0, dw});
	assign gey     = (ry_sh >= {1'b0, dh});
	assign rx_sub  = rx_sh - {1'b0, dw};
	assign ry_sub  = ry_sh - {1'b0, dh};
	assign qx_sh   = {qx_q, gex};
	assign qy_sh   = {qy_q, gey};
	assign nx_sh   = {nx_q, 1'b0};
	assign ny_sh   = {ny_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rx_q <= nx_init[RW-1:0];
			ry_q <= ny_init[RW-1:0];
			nx_q <= num_x_q[QW-1:0];
			ny_q <= num_y_q[QW-1:0];
			qx_q <= '0;
			qy_q <= '0;
		end else if (cmd.div_step) begin
			rx_q <= gex ? rx_sub[RW-1:0] : rx_sh[RW-1:0];
			ry_q <= gey ? ry_sub[RW-1:0] : ry_sh[RW-1:0];
			nx_q <= nx_sh[QW-1:0];
			ny_q <= ny_sh[QW-1:0];
			qx_q <= qx_sh[QW-1:0];
			qy_q <= qy_sh[QW-1:0];
		end
	end

	// right and lower neighbors clamp to the last column and row
	assign ox     = qx_q[XW-1:0];
	assign oy     = qy_q[YW-1:0];
	assign ox_inc = {1'b0, ox} + (XW+1)'(1);
	assign oy_inc = {1'b0, oy} + (YW+1)'(1);
	assign ox1    = (DST_DIM_W'(ox_inc) < DST_DIM_W'(sw)) ? ox_inc[XW-1:0] : ox;
	assign oy1    = (DST_DIM_W'(oy_inc) < DST_DIM_W'(sh)) ? oy_inc[YW-1:0] : oy;

	// store access: write takes the item coordinates, reads the neighbor
	assign wr_ok  = ({1'b0, col_q} < MAX_W_C) && ({1'b0, row_q} < MAX_H_C);
	assign mem_we = cmd.wr && wr_ok;

	always_comb begin
		if (cmd.wr) begin
			ax = col_q[XW-1:0];
			ay = row_q[YW-1:0];
		end else begin
			ax = cmd.rd_sel[0] ? ox1 : ox;
			ay = cmd.rd_sel[1] ? oy1 : oy;
		end
		addr = AW'(AW'(ay) * AW'(MAX_SRC_WIDTH)) + AW'(ax);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= pix_q;
		end else if (cmd.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_first_s1 <= (cmd.rd_sel == NBR_BASE);
		end
	end

	// per-byte sums of the fetched neighbors
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			for (int i = 0; i < PIX_BYTES; i++) begin
				acc_q[i] <= (rd_first_s1 ? ACC_W'(0) : acc_q[i])
					+ ACC_W'(rd_data_s1[8*i +: 8]);
			end
		end
	end

	always_comb begin
		result = '0;
		for (int i = 0; i < PIX_BYTES; i++) begin
			if (BPP_W'(i) < nb) begin
				result[8*i +: 8] = (mode_q == MODE_NEAREST) ? acc_q[i][7:0] : acc_q[i][9:2];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q.pixel_out <= sts.oob ? '0 : result;
			out_word_q.status    <= sts.oob ? STATUS_RANGE : STATUS_OK;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_word     = out_word_q;
	assign sts.is_req   = is_req_q;
	assign sts.oob      = ({1'b0, col_q} >= dw) || ({1'b0, row_q} >= dh);
	assign sts.nearest  = (mode_q == MODE_NEAREST);
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

// ===== rtl/core/image_resize_box_nearest.sv =====
// ----------------------------------------------------------------------------
// image_resize_box_nearest
// nearest / 2x2 box image scaler over a single-port source frame store
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  in        into       in_valid / in_stall    in_word_t  (cmd, col, row, pixel_in)
//  out       out of     out_valid / out_stall  out_word_t (pixel_out, status)
//  cfg       into       cfg_we                 cfg_index, cfg_data
//
//  a write word goes accept, check, store; a request outside the destination
//  goes accept, check, emit; an in-range request also runs the bit-serial divider
//  for a Q-bit quotient, Q = clog2(max(MAX_SRC_WIDTH, MAX_SRC_HEIGHT)), then reads
//  the store port (once nearest, four times box) and drains before it emits
//  reset clears control and config only; the frame store holds garbage
//  until written and needs no clearing pass
//  a finished result waits in the output register while new words are taken
//
module image_resize_box_nearest
	import irbn_pkg::*;
#(
	parameter int MAX_SRC_WIDTH  = MAX_SRC_WIDTH_DEF,
	parameter int MAX_SRC_HEIGHT = MAX_SRC_HEIGHT_DEF,
	parameter int MAX_BYTES      = MAX_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	// result words
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word
);

	// divider length: one quotient bit per cycle for the wider coordinate
	localparam int XW = $clog2(MAX_SRC_WIDTH);
	localparam int YW = $clog2(MAX_SRC_HEIGHT);
	localparam int QW = (XW > YW) ? XW : YW;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer
	irbn_ctrl #(
		.DIV_STEPS(QW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// config, dividers, frame store, accumulators and output register
	irbn_datapath #(
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
		.MAX_BYTES      (MAX_BYTES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== rtl/core/irbn_checker.sv =====
// ----------------------------------------------------------------------------
// irbn_checker
// port-level checks of the scaler, bound to the top level
// ----------------------------------------------------------------------------
module irbn_checker
	import irbn_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_word_t  in_word,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	// a stalled input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("input word changed while stalled");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its word
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_word))
		else $error("result word changed while stalled");

	// range error results carry no pixel bytes
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_word.status == STATUS_RANGE) |-> (out_word.pixel_out == '0))
		else $error("range error with nonzero pixel");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken back to back");

endmodule

bind image_resize_box_nearest irbn_checker u_irbn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ===== verif/image_resize_box_nearest_tb.sv =====
// ----------------------------------------------------------------------------
// image_resize_box_nearest_tb
// self-checking bench for the nearest / 2x2 box image scaler
// a short table of hand-picked words with known results, then random phases
// each under its own register setting; a behavioral copy of the frame store
// and the scaling arithmetic predicts every random-phase result word, and both handshakes
// see random gaps and stalls
// ----------------------------------------------------------------------------
module image_resize_box_nearest_tb;
	import irbn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// run limits
	localparam int LIMIT_CYCLES  = 1_000_000;
	// settle wait after the last owed result, margin for a trailing write
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_COUNT   = 9;
	localparam int PHASE_WORDS   = 45;
	localparam int MAX_REPORTS   = 10;
	localparam int FULL_COORD    = 4096;

	// register indexes past the last register, writes there change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	// directed table rows
	typedef enum logic [1:0] {STEP_REG, STEP_WORD, STEP_TYPED} step_kind_e;

	typedef struct packed {
		step_kind_e            kind;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		in_word_t              word;
		out_word_t             result;
	} plan_step_t;

	// block pins, the driven ones known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_word_t              in_word   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_word_t             out_word;

	// shadow of the block's registers, raw as written
	logic [SRC_DIM_W-1:0] reg_src_w = SRC_WIDTH_RST;
	logic [SRC_DIM_W-1:0] reg_src_h = SRC_HEIGHT_RST;
	logic [DST_DIM_W-1:0] reg_dst_w = DST_WIDTH_RST;
	logic [DST_DIM_W-1:0] reg_dst_h = DST_HEIGHT_RST;
	logic [BPP_W-1:0]     reg_bpp   = BPP_RST;
	logic                 reg_mode  = MODE_BOX;

	// shadow of the frame store, only entries written since reset exist
	logic [PIX_W-1:0] frame_copy [int unsigned];

	// result words still owed by the block, oldest first
	out_word_t pending_pixels [$];
	plan_step_t directed_plan [$];

	int  err_count     = 0;
	int  cycle_count   = 0;
	int  useful_words  = 0;
	int  stall_hold    = 0;
	bit  steady_sender = 1'b0;

	image_resize_box_nearest dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// effective geometry: out-of-range register values fold back in
	// ------------------------------------------------------------------
	function automatic int unsigned eff_src_w();
		if (reg_src_w == 0) return 1;
		return (reg_src_w > MAX_SRC_WIDTH_DEF) ? MAX_SRC_WIDTH_DEF : reg_src_w;
	endfunction

	function automatic int unsigned eff_src_h();
		if (reg_src_h == 0) return 1;
		return (reg_src_h > MAX_SRC_HEIGHT_DEF) ? MAX_SRC_HEIGHT_DEF : reg_src_h;
	endfunction

	// a zero destination size acts as one pixel
	function automatic int unsigned eff_dst_w();
		return (reg_dst_w == 0) ? 1 : reg_dst_w;
	endfunction

	function automatic int unsigned eff_dst_h();
		return (reg_dst_h == 0) ? 1 : reg_dst_h;
	endfunction

	function automatic int unsigned eff_bytes();
		int unsigned top;
		top = (MAX_BYTES_DEF < PIX_BYTES) ? MAX_BYTES_DEF : PIX_BYTES;
		if (reg_bpp == 0) return 1;
		return (reg_bpp > top) ? top : reg_bpp;
	endfunction

	// destination pixel to source taps; right and bottom neighbors clamp
	// at the last column and row, nearest collapses all taps onto the base
	function automatic void map_source(input int unsigned col, input int unsigned row,
			output int unsigned ox, output int unsigned oy,
			output int unsigned ox1, output int unsigned oy1);
		ox  = (col * eff_src_w()) / eff_dst_w();
		oy  = (row * eff_src_h()) / eff_dst_h();
		ox1 = (ox + 1 < eff_src_w()) ? ox + 1 : eff_src_w() - 1;
		oy1 = (oy + 1 < eff_src_h()) ? oy + 1 : eff_src_h() - 1;
		if (reg_mode == MODE_NEAREST) begin
			ox1 = ox;
			oy1 = oy;
		end
	endfunction

	function automatic int unsigned store_addr(input int unsigned x, input int unsigned y);
		return y * MAX_SRC_WIDTH_DEF + x;
	endfunction

	// expected result of one request; nearest is the box mean of four
	// identical taps, which gives the base pixel unchanged
	function automatic out_word_t scale_pixel(input int unsigned col, input int unsigned row);
		out_word_t        res;
		int unsigned      ox, oy, ox1, oy1, addr, nb;
		int unsigned      sum [PIX_BYTES];
		logic [PIX_W-1:0] tap;
		int               k, b;
		res.pixel_out = '0;
		res.status    = STATUS_OK;
		if (col >= eff_dst_w() || row >= eff_dst_h()) begin
			res.status = STATUS_RANGE;
			return res;
		end
		map_source(col, row, ox, oy, ox1, oy1);
		for (b = 0; b < PIX_BYTES; b++) sum[b] = 0;
		for (k = 0; k < 4; k++) begin
			addr = store_addr(k[0] ? ox1 : ox, k[1] ? oy1 : oy);
			tap  = frame_copy.exists(addr) ? frame_copy[addr] : '0;
			for (b = 0; b < PIX_BYTES; b++) sum[b] += tap[8*b +: 8];
		end
		nb = eff_bytes();
		for (b = 0; b < PIX_BYTES; b++) begin
			if (b < nb) res.pixel_out[8*b +: 8] = 8'(sum[b] >> 2);
		end
		return res;
	endfunction

	function automatic in_word_t make_word(input logic cmd, input int unsigned col,
			input int unsigned row, input logic [PIX_W-1:0] pix);
		in_word_t w;
		w.cmd      = cmd;
		w.col      = COL_W'(col);
		w.row      = ROW_W'(row);
		w.pixel_in = pix;
		return w;
	endfunction

	// mostly random bytes, now and then all ones or all zeros
	function automatic logic [PIX_W-1:0] random_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '1;
		if (r == 1) return '0;
		return $urandom;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_sender) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	function automatic void flag_error(input string what, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s expected %h got %h",
				cycle_count, what, want, got);
	endfunction

	// ------------------------------------------------------------------
	// directed table builders
	// ------------------------------------------------------------------
	function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		plan_step_t s;
		s         = '0;
		s.kind    = STEP_REG;
		s.reg_idx = idx;
		s.reg_val = val;
		directed_plan.push_back(s);
	endfunction

	function automatic void plan_write(input int unsigned col, input int unsigned row,
			input logic [PIX_W-1:0] pix);
		plan_step_t s;
		s      = '0;
		s.kind = STEP_WORD;
		s.word = make_word(CMD_WRITE, col, row, pix);
		directed_plan.push_back(s);
	endfunction

	// request with its result typed in
	function automatic void plan_request(input int unsigned col, input int unsigned row,
			input logic [PIX_W-1:0] pix_out, input logic status);
		plan_step_t s;
		s                  = '0;
		s.kind             = STEP_TYPED;
		s.word             = make_word(CMD_REQUEST, col, row, $urandom);
		s.result.pixel_out = pix_out;
		s.result.status    = status;
		directed_plan.push_back(s);
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one word on the input channel; valid stays up when no gap follows,
	// so the next call takes over in the same step
	task automatic push_word(input in_word_t w, input bit typed, input out_word_t typed_res);
		int gap;
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		// accepted at this edge, update the shadow in block order
		if (w.cmd == CMD_WRITE) begin
			if (w.col < MAX_SRC_WIDTH_DEF && w.row < MAX_SRC_HEIGHT_DEF) begin
				frame_copy[store_addr(w.col, w.row)] = w.pixel_in;
				useful_words++;
			end
		end else begin
			pending_pixels.push_back(typed ? typed_res : scale_pixel(w.col, w.row));
			useful_words++;
		end
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending, wait for every owed word, then let a trailing write finish
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only called with the block idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SRC_WIDTH:  reg_src_w = val[SRC_DIM_W-1:0];
			CFG_SRC_HEIGHT: reg_src_h = val[SRC_DIM_W-1:0];
			CFG_DST_WIDTH:  reg_dst_w = val[DST_DIM_W-1:0];
			CFG_DST_HEIGHT: reg_dst_h = val[DST_DIM_W-1:0];
			CFG_BPP:        reg_bpp   = val[BPP_W-1:0];
			CFG_MODE:       reg_mode  = val[0];
			default: ;
		endcase
	endtask

	// request one destination pixel, first loading any source tap it
	// reads that was never written
	task automatic request_pixel(input int unsigned col, input int unsigned row);
		int unsigned ox, oy, ox1, oy1, tx, ty;
		int          k;
		if (col < eff_dst_w() && row < eff_dst_h()) begin
			map_source(col, row, ox, oy, ox1, oy1);
			for (k = 0; k < 4; k++) begin
				tx = k[0] ? ox1 : ox;
				ty = k[1] ? oy1 : oy;
				if (!frame_copy.exists(store_addr(tx, ty)))
					push_word(make_word(CMD_WRITE, tx, ty, random_pixel()), 1'b0, '0);
			end
		end
		push_word(make_word(CMD_REQUEST, col, row, $urandom), 1'b0, '0);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_src_dim();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return '0;
			1:       return CFG_DATA_W'(1);
			2:       return CFG_DATA_W'(MAX_SRC_WIDTH_DEF);
			3:       return CFG_DATA_W'($urandom_range(0, 8191));
			4, 5:    return CFG_DATA_W'($urandom_range(1, 256));
			default: return CFG_DATA_W'($urandom_range(1, 16));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_dst_dim();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return '0;
			1:       return CFG_DATA_W'(1);
			2:       return CFG_DATA_W'(FULL_COORD);
			3:       return CFG_DATA_W'(8191);
			4:       return CFG_DATA_W'($urandom_range(0, 8191));
			5, 6:    return CFG_DATA_W'($urandom_range(1, 64));
			default: return CFG_DATA_W'($urandom_range(1, 512));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// result side: random stall and in-order checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin : result_side
		out_word_t want;
		int        r;
		logic      stall_next;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				flag_error("result with none owed, pixel_out", '0, out_word.pixel_out);
			end else begin
				want = pending_pixels.pop_front();
				if (out_word.pixel_out !== want.pixel_out)
					flag_error("pixel_out", want.pixel_out, out_word.pixel_out);
				if (out_word.status !== want.status)
					flag_error("status", PIX_W'(want.status), PIX_W'(out_word.status));
			end
		end
		// stall runs: short ones mostly, some long stalls and calm stretches
		if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				stall_next = 1'b0;
				stall_hold = $urandom_range(0, 3);
			end else if (r < 85) begin
				stall_next = 1'b1;
				stall_hold = $urandom_range(0, 2);
			end else if (r < 95) begin
				stall_next = 1'b0;
				stall_hold = $urandom_range(20, 60);
			end else begin
				stall_next = 1'b1;
				stall_hold = $urandom_range(10, 30);
			end
			out_stall <= stall_next;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAIL image_resize_box_nearest");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned col, row, dw_lim, dh_lim;
		int          phase, r;
		bit          paused;
		logic [CFG_DATA_W-1:0] sw_val, sh_val, dw_val, dh_val;

		// requests outside the reset destination size
		plan_request(256, 0, '0, STATUS_RANGE);
		plan_request(4095, 4095, '0, STATUS_RANGE);
		// corner 2x2 block, box mean truncates byte 0 to fe
		plan_write(0, 0, 32'hFFFF_FFFF);
		plan_write(1, 0, 32'hFFFF_FFFF);
		plan_write(0, 1, 32'hFFFF_FFFF);
		plan_write(1, 1, 32'hFFFF_FFFC);
		plan_request(0, 0, 32'hFFFF_FFFE, STATUS_OK);
		// writes outside the store are dropped
		plan_write(4095, 4095, 32'h1234_5678);
		plan_write(256, 0, 32'hA5A5_A5A5);
		plan_write(0, 256, 32'h5A5A_5A5A);
		// bottom-right corner, all four taps clamp onto one pixel
		plan_write(255, 255, 32'h0102_0304);
		plan_request(255, 255, 32'h0102_0304, STATUS_OK);
		// nearest, then the byte count and its folding
		plan_reg(CFG_MODE, 13'(MODE_NEAREST));
		plan_request(1, 1, 32'hFFFF_FFFC, STATUS_OK);
		plan_reg(CFG_BPP, 13'd1);
		plan_request(1, 1, 32'h0000_00FC, STATUS_OK);
		plan_reg(CFG_BPP, 13'd0);
		plan_request(1, 1, 32'h0000_00FC, STATUS_OK);
		plan_reg(CFG_BPP, 13'd3);
		plan_request(1, 1, 32'h00FF_FFFC, STATUS_OK);
		plan_reg(CFG_BPP, 13'd7);
		plan_request(1, 1, 32'hFFFF_FFFC, STATUS_OK);
		// one-pixel source blown up to the largest destination
		plan_reg(CFG_MODE, 13'(MODE_BOX));
		plan_reg(CFG_SRC_WIDTH, 13'd1);
		plan_reg(CFG_SRC_HEIGHT, 13'd1);
		plan_reg(CFG_DST_WIDTH, 13'(FULL_COORD));
		plan_reg(CFG_DST_HEIGHT, 13'(FULL_COORD));
		plan_request(4095, 4095, 32'hFFFF_FFFF, STATUS_OK);
		// zero sizes act as one
		plan_reg(CFG_SRC_WIDTH, 13'd0);
		plan_reg(CFG_SRC_HEIGHT, 13'd0);
		plan_reg(CFG_DST_WIDTH, 13'd0);
		plan_reg(CFG_DST_HEIGHT, 13'd0);
		plan_request(1, 0, '0, STATUS_RANGE);
		plan_request(0, 1, '0, STATUS_RANGE);
		plan_request(0, 0, 32'hFFFF_FFFF, STATUS_OK);
		// all-ones register data: source folds to 256, destination 8191
		plan_reg(CFG_SRC_WIDTH, '1);
		plan_reg(CFG_SRC_HEIGHT, '1);
		plan_reg(CFG_DST_WIDTH, '1);
		plan_reg(CFG_DST_HEIGHT, '1);
		plan_request(31, 31, 32'hFFFF_FFFE, STATUS_OK);
		// spare indexes must not disturb anything
		plan_reg(CFG_SPARE_A, '1);
		plan_reg(CFG_SPARE_B, '1);
		plan_request(0, 0, 32'hFFFF_FFFE, STATUS_OK);

		// reset, asserted from time zero, then released
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				STEP_REG: begin
					drain_results();
					write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
				end
				STEP_WORD:  push_word(directed_plan[i].word, 1'b0, '0);
				STEP_TYPED: push_word(directed_plan[i].word, 1'b1, directed_plan[i].result);
				default: ;
			endcase
		end

		// random phases, each under a fresh register setting
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			drain_results();
			sw_val = pick_src_dim();
			sh_val = pick_src_dim();
			dw_val = pick_dst_dim();
			dh_val = pick_dst_dim();
			// strongest shrink first, then strongest blow-up
			if (phase == 0) begin
				sw_val = CFG_DATA_W'(MAX_SRC_WIDTH_DEF);
				sh_val = CFG_DATA_W'(MAX_SRC_HEIGHT_DEF);
				dw_val = CFG_DATA_W'(1);
				dh_val = CFG_DATA_W'(1);
			end else if (phase == 1) begin
				sw_val = CFG_DATA_W'(1);
				sh_val = CFG_DATA_W'(1);
				dw_val = CFG_DATA_W'(FULL_COORD);
				dh_val = CFG_DATA_W'(FULL_COORD);
			end
			write_reg(CFG_SRC_WIDTH, sw_val);
			write_reg(CFG_SRC_HEIGHT, sh_val);
			write_reg(CFG_DST_WIDTH, dw_val);
			write_reg(CFG_DST_HEIGHT, dh_val);
			write_reg(CFG_BPP, CFG_DATA_W'($urandom_range(0, 8191)));
			write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 8191)));
			steady_sender = ($urandom_range(0, 3) == 0);
			useful_words  = 0;
			paused        = 1'b0;

			while (useful_words < PHASE_WORDS) begin
				// hold the sender until the block has emptied out
				if (phase % 3 == 1 && !paused && useful_words >= PHASE_WORDS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				dw_lim = (eff_dst_w() < FULL_COORD) ? eff_dst_w() : FULL_COORD;
				dh_lim = (eff_dst_h() < FULL_COORD) ? eff_dst_h() : FULL_COORD;
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// in-range request, edges favored
					col = ($urandom_range(0, 4) == 0) ? dw_lim - 1 : $urandom_range(0, dw_lim - 1);
					row = ($urandom_range(0, 4) == 0) ? dh_lim - 1 : $urandom_range(0, dh_lim - 1);
					request_pixel(col, row);
				end else if (r < 70 && (eff_dst_w() < FULL_COORD || eff_dst_h() < FULL_COORD)) begin
					// request outside the destination
					if (eff_dst_w() < FULL_COORD && ($urandom_range(0, 1) || eff_dst_h() >= FULL_COORD)) begin
						col = $urandom_range(eff_dst_w(), 4095);
						row = $urandom_range(0, 4095);
					end else begin
						col = $urandom_range(0, 4095);
						row = $urandom_range(eff_dst_h(), 4095);
					end
					request_pixel(col, row);
				end else if (r < 90) begin
					// overwrite inside the store, often inside the source area
					if ($urandom_range(0, 1)) begin
						col = $urandom_range(0, eff_src_w() - 1);
						row = $urandom_range(0, eff_src_h() - 1);
					end else begin
						col = $urandom_range(0, MAX_SRC_WIDTH_DEF - 1);
						row = $urandom_range(0, MAX_SRC_HEIGHT_DEF - 1);
					end
					push_word(make_word(CMD_WRITE, col, row, random_pixel()), 1'b0, '0);
				end else begin
					// dropped write past the store
					if ($urandom_range(0, 1)) begin
						col = $urandom_range(MAX_SRC_WIDTH_DEF, 4095);
						row = $urandom_range(0, 4095);
					end else begin
						col = $urandom_range(0, 4095);
						row = $urandom_range(MAX_SRC_HEIGHT_DEF, 4095);
					end
					push_word(make_word(CMD_WRITE, col, row, $urandom), 1'b0, '0);
				end
			end
		end

		// wait out every owed word plus the tail of the last write
		drain_results();
		if (err_count == 0) begin
			$display("PASS image_resize_box_nearest");
		end else begin
			$display("FAIL image_resize_box_nearest");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/irbn_pkg.sv
rtl/core/irbn_ctrl.sv
rtl/core/irbn_datapath.sv
rtl/core/image_resize_box_nearest.sv
rtl/core/irbn_checker.sv
verif/image_resize_box_nearest_tb.sv
